// ===== rtl/mbrf_pkg.sv =====
// shared types, constants and crc helper for the modbus read request framer
`default_nettype none

package mbrf_pkg;

	localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
	localparam logic [15:0] CRC_INIT          = 16'hFFFF;
	localparam logic [15:0] CRC_POLY          = 16'hA001;
	localparam logic [7:0]  DEV_ADDR_RESET    = 8'h01;

	localparam logic [2:0] IDX_ADDR     = 3'd0;
	localparam logic [2:0] IDX_FUNC     = 3'd1;
	localparam logic [2:0] IDX_START_HI = 3'd2;
	localparam logic [2:0] IDX_START_LO = 3'd3;
	localparam logic [2:0] IDX_COUNT_HI = 3'd4;
	localparam logic [2:0] IDX_COUNT_LO = 3'd5;
	localparam logic [2:0] IDX_CRC_LO   = 3'd6;
	localparam logic [2:0] IDX_CRC_HI   = 3'd7;

	typedef struct packed {
		logic [7:0]  dev_addr;
		logic [15:0] start_reg;
		logic [6:0]  reg_count;
	} req_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/mbrf_front.sv =====
// front end: address register, item capture and two-entry request queue
`default_nettype none

module mbrf_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  wire logic [7:0]     cfg_wdata,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [15:0]    in_start_reg,
	input  wire logic [6:0]     in_reg_count,
	output logic                req_valid,
	input  wire logic           req_ready,
	output mbrf_pkg::req_t      req
);

	logic [7:0]     dev_addr_q;
	mbrf_pkg::req_t queue_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	logic           pop;

	assign in_ready  = (count_q != 2'd2);
	assign req_valid = (count_q != 2'd0);
	assign push      = in_valid && in_ready;
	assign pop       = req_valid && req_ready;
	assign req       = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= mbrf_pkg::DEV_ADDR_RESET;
		end else if (cfg_we) begin
			dev_addr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= '{dev_addr: dev_addr_q, start_reg: in_start_reg,
				reg_count: in_reg_count};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

// ===== rtl/mbrf_back.sv =====
// back end: byte serializer with running crc and output register
`default_nettype none

module mbrf_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire mbrf_pkg::req_t req,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [7:0]          out_byte,
	output logic                out_last
);

	mbrf_pkg::req_t cur_q;
	logic           busy_q;
	logic [2:0]     idx_q;
	logic [15:0]    crc_q;
	logic           m_valid_q;
	logic [7:0]     m_byte_q;
	logic           m_last_q;
	logic           advance;
	logic           emit;
	logic           final_emit;
	logic [7:0]     byte_sel;

	assign advance    = !m_valid_q || out_ready;
	assign emit       = busy_q && advance;
	assign final_emit = emit && (idx_q == mbrf_pkg::IDX_CRC_HI);
	assign req_ready  = !busy_q || final_emit;

	assign out_valid = m_valid_q;
	assign out_byte  = m_byte_q;
	assign out_last  = m_last_q;

	always_comb begin
		case (idx_q)
			mbrf_pkg::IDX_ADDR:     byte_sel = cur_q.dev_addr;
			mbrf_pkg::IDX_FUNC:     byte_sel = mbrf_pkg::FUNC_READ_HOLDING;
			mbrf_pkg::IDX_START_HI: byte_sel = cur_q.start_reg[15:8];
			mbrf_pkg::IDX_START_LO: byte_sel = cur_q.start_reg[7:0];
			mbrf_pkg::IDX_COUNT_HI: byte_sel = 8'h00;
			mbrf_pkg::IDX_COUNT_LO: byte_sel = {1'b0, cur_q.reg_count};
			mbrf_pkg::IDX_CRC_LO:   byte_sel = crc_q[7:0];
			mbrf_pkg::IDX_CRC_HI:   byte_sel = crc_q[15:8];
			default:                byte_sel = 8'h00;
		endcase
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			cur_q <= req;
		end
		if (emit) begin
			m_byte_q <= byte_sel;
			m_last_q <= (idx_q == mbrf_pkg::IDX_CRC_HI);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			idx_q     <= mbrf_pkg::IDX_ADDR;
			crc_q     <= mbrf_pkg::CRC_INIT;
			m_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				m_valid_q <= busy_q;
			end
			if (req_valid && req_ready) begin
				busy_q <= 1'b1;
				idx_q  <= mbrf_pkg::IDX_ADDR;
				crc_q  <= mbrf_pkg::CRC_INIT;
			end else if (final_emit) begin
				busy_q <= 1'b0;
				idx_q  <= mbrf_pkg::IDX_ADDR;
			end else if (emit) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q < mbrf_pkg::IDX_CRC_LO) begin
					crc_q <= mbrf_pkg::crc_byte(crc_q, byte_sel);
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (idx_q == mbrf_pkg::IDX_ADDR))
		else $error("byte index not at start while idle");
	a_crc_start: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && idx_q == mbrf_pkg::IDX_ADDR) |-> (crc_q == mbrf_pkg::CRC_INIT))
		else $error("crc not seeded at frame start");
	a_last_beat: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (m_valid_q && (m_last_q == ($past(idx_q) == mbrf_pkg::IDX_CRC_HI))))
		else $error("last flag does not match frame position");
`endif

endmodule

`default_nettype wire

// ===== rtl/modbus_read_request_framer.sv =====
// top level of the modbus read holding registers request framer
//
// channel  | dir | beat content
// s_axis   | in  | tdata[15:0] start register, tdata[22:16] register count
// m_axis   | out | tdata[7:0] frame byte, tlast on crc high byte
// cfg      | in  | cfg_wdata device address, written when cfg_we
//
// each request leaves as eight beats, one per cycle while m_axis_tready stays high
// the byte serializer paces the output; a two-entry queue lets requests wait meanwhile
// when idle, a request beat passes the queue, the serializer request register and the output register
// reset clears queue, serializer and output register; device address resets to 1
// a stall on m_axis holds the output register and fills the queue, then drops s_axis_tready
`default_nettype none

module modbus_read_request_framer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // start_register, register_count, pad
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // frame_byte
	output logic             m_axis_tlast
);

	logic           req_valid;
	logic           req_ready;
	mbrf_pkg::req_t req;

	mbrf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_start_reg (s_axis_tdata[15:0]),
		.in_reg_count (s_axis_tdata[22:16]),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req          (req)
	);

	mbrf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

`default_nettype wire
